// File: hdl/lbmd_pkg.sv
// Shared types, register indexes, reset values and the Morse step table for the LED driver.
package lbmd_pkg;

	localparam int unsigned PATTERN_STEPS_DEF = 12;
	localparam int unsigned TIME_BITS_DEF     = 32;

	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned UNIT_W      = 12;
	localparam int unsigned HALF_W      = 16;
	localparam int unsigned STEP_UNITS_W = 2;
	localparam int unsigned DUR_W       = UNIT_W + STEP_UNITS_W;

	// register indexes on the config port
	localparam logic [CFG_INDEX_W-1:0] REG_FAST_HALF   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOW_HALF   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MORSE_UNIT  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH = 2'd3;

	// requested LED modes
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_SOLID = 2'd1;
	localparam logic [1:0] MODE_FAST  = 2'd2;
	localparam logic [1:0] MODE_SLOW  = 2'd3;

	localparam logic [HALF_W-1:0] FAST_HALF_RST   = 16'd180;
	localparam logic [HALF_W-1:0] SLOW_HALF_RST   = 16'd520;
	localparam logic [UNIT_W-1:0] MORSE_UNIT_RST  = 12'd70;
	localparam logic              ACTIVE_HIGH_RST = 1'b1;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [1:0]  mode;
		logic        start_morse;
	} tick_t;

	typedef struct packed {
		logic pin_level;
		logic led_lit;
		logic morse_busy;
	} led_out_t;

	// length of each pattern step in units; steps past the word last one unit
	function automatic logic [STEP_UNITS_W-1:0] step_units(input logic [3:0] step);
		logic [STEP_UNITS_W-1:0] u;
		unique case (step)
			4'd0:    u = 2'd3;
			4'd1:    u = 2'd1;
			4'd2:    u = 2'd3;
			4'd3:    u = 2'd1;
			4'd4:    u = 2'd1;
			4'd5:    u = 2'd3;
			4'd6:    u = 2'd3;
			4'd7:    u = 2'd1;
			4'd8:    u = 2'd3;
			4'd9:    u = 2'd1;
			4'd10:   u = 2'd3;
			4'd11:   u = 2'd3;
			default: u = 2'd1;
		endcase
		return u;
	endfunction

endpackage

// File: hdl/led_blink_morse_driver.sv
// LED blink controller with Morse pattern playback: top level.
// A tick accepted into the input register has its result written to the result
// register on out_data, and held there while out_ready is low.
// Throughput: one tick per cycle unless a held result stalls it; the state update
// is one pass of compare and small multiply logic between the input register and
// the result register. Reset: arst_n clears the pipeline, the playback and blink
// state (LED dark, mode off) and loads the default half-periods, unit and polarity.
module led_blink_morse_driver #(
	parameter int unsigned PATTERN_STEPS = lbmd_pkg::PATTERN_STEPS_DEF,
	parameter int unsigned TIME_BITS     = lbmd_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  lbmd_pkg::tick_t                    in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output lbmd_pkg::led_out_t                 out_data,
	input  logic                               cfg_we,
	input  logic [lbmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lbmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned IDX_W = $clog2(PATTERN_STEPS + 1);

	// configuration
	logic [lbmd_pkg::HALF_W-1:0] fast_half_q;
	logic [lbmd_pkg::HALF_W-1:0] slow_half_q;
	logic [lbmd_pkg::UNIT_W-1:0] morse_unit_q;
	logic                        active_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_half_q   <= lbmd_pkg::FAST_HALF_RST;
			slow_half_q   <= lbmd_pkg::SLOW_HALF_RST;
			morse_unit_q  <= lbmd_pkg::MORSE_UNIT_RST;
			active_high_q <= lbmd_pkg::ACTIVE_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbmd_pkg::REG_FAST_HALF:   fast_half_q   <= cfg_data;
				lbmd_pkg::REG_SLOW_HALF:   slow_half_q   <= cfg_data;
				lbmd_pkg::REG_MORSE_UNIT:  morse_unit_q  <= cfg_data[lbmd_pkg::UNIT_W-1:0];
				lbmd_pkg::REG_ACTIVE_HIGH: active_high_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic            valid_s1;
	lbmd_pkg::tick_t tick_s1;
	logic            out_valid_q;
	logic            advance;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1 <= in_data;
		end
	end

	// block state
	logic                 running_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TIME_BITS-1:0] phase_start_q;
	logic [1:0]           applied_mode_q;
	logic                 blink_level_q;
	logic [TIME_BITS-1:0] last_toggle_q;
	logic                 lit_q;

	logic                 running_d;
	logic [IDX_W-1:0]     idx_d;
	logic [TIME_BITS-1:0] phase_start_d;
	logic [1:0]           applied_mode_d;
	logic                 blink_level_d;
	logic [TIME_BITS-1:0] last_toggle_d;
	logic                 lit_d;
	logic                 busy_c;

	logic [TIME_BITS-1:0]           now_t;
	logic [3:0]                     idx_ext;
	logic [lbmd_pkg::DUR_W-1:0]     dur;
	logic [lbmd_pkg::HALF_W-1:0]    half;
	logic [TIME_BITS-1:0]           morse_elapsed;
	logic [TIME_BITS-1:0]           blink_elapsed;

	assign now_t   = TIME_BITS'(tick_s1.now_ms);
	assign half    = (tick_s1.mode == lbmd_pkg::MODE_FAST) ? fast_half_q : slow_half_q;

	always_comb begin
		running_d      = running_q;
		idx_d          = idx_q;
		phase_start_d  = phase_start_q;
		applied_mode_d = applied_mode_q;
		blink_level_d  = blink_level_q;
		last_toggle_d  = last_toggle_q;
		lit_d          = lit_q;
		busy_c         = 1'b0;

		// a start request restarts playback before anything else
		if (tick_s1.start_morse) begin
			running_d     = 1'b1;
			idx_d         = '0;
			phase_start_d = now_t;
		end

		idx_ext       = 4'(idx_d);
		dur           = lbmd_pkg::DUR_W'(lbmd_pkg::step_units(idx_ext)) *
			lbmd_pkg::DUR_W'(morse_unit_q);
		morse_elapsed = now_t - phase_start_d;

		if (running_d && (32'(idx_d) >= 32'(PATTERN_STEPS))) begin
			// pattern over: mode logic takes this tick
			running_d = 1'b0;
			idx_d     = '0;
		end else if (running_d) begin
			busy_c = 1'b1;
			lit_d  = !idx_d[0];
			if (morse_elapsed >= TIME_BITS'(dur)) begin
				idx_d         = idx_d + IDX_W'(1);
				phase_start_d = now_t;
			end
		end

		if (!busy_c) begin
			if (tick_s1.mode != applied_mode_d) begin
				applied_mode_d = tick_s1.mode;
				last_toggle_d  = now_t;
				if (tick_s1.mode[1]) begin
					blink_level_d = 1'b1;
					lit_d         = 1'b1;
				end
			end
		end

		blink_elapsed = now_t - last_toggle_d;

		if (!busy_c) begin
			unique case (tick_s1.mode)
				lbmd_pkg::MODE_OFF: begin
					blink_level_d = 1'b0;
					lit_d         = 1'b0;
				end
				lbmd_pkg::MODE_SOLID: begin
					blink_level_d = 1'b1;
					lit_d         = 1'b1;
				end
				default: begin
					if (blink_elapsed > TIME_BITS'(half)) begin
						last_toggle_d = now_t;
						blink_level_d = !blink_level_d;
						lit_d         = blink_level_d;
					end
				end
			endcase
		end
	end

	logic tick_go;
	assign tick_go = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q      <= 1'b0;
			idx_q          <= '0;
			phase_start_q  <= '0;
			applied_mode_q <= lbmd_pkg::MODE_OFF;
			blink_level_q  <= 1'b0;
			last_toggle_q  <= '0;
			lit_q          <= 1'b0;
		end else if (tick_go) begin
			running_q      <= running_d;
			idx_q          <= idx_d;
			phase_start_q  <= phase_start_d;
			applied_mode_q <= applied_mode_d;
			blink_level_q  <= blink_level_d;
			last_toggle_q  <= last_toggle_d;
			lit_q          <= lit_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			out_data.pin_level  <= lit_d ^ !active_high_q;
			out_data.led_lit    <= lit_d;
			out_data.morse_busy <= busy_c;
		end
	end

	// checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) <= 32'(PATTERN_STEPS))
		else $error("pattern index past end");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> idx_q == '0)
		else $error("index not cleared while playback idle");

	a_busy_keeps_run: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go && busy_c |=> running_q)
		else $error("playback dropped on a busy beat");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(tick_s1))
		else $error("stalled beat lost in input stage");

endmodule

// File: test/lbmd_checker.sv
// Watches the tick and LED channels, predicts each LED result and compares it.
module lbmd_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  lbmd_pkg::tick_t                  in_data,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  lbmd_pkg::led_out_t               out_data,
	input  logic                             cfg_we,
	input  logic [lbmd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lbmd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int unsigned                      fails,
	output int unsigned                      pending,
	output int unsigned                      results_seen,
	output int unsigned                      busy_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// units per step of the spoken word, lit on even steps
	localparam int unsigned STEP_LEN [12] = '{3, 1, 3, 1, 1, 3, 3, 1, 3, 1, 3, 3};

	logic [lbmd_pkg::HALF_W-1:0] fast_half;
	logic [lbmd_pkg::HALF_W-1:0] slow_half;
	logic [lbmd_pkg::UNIT_W-1:0] unit_ms;
	logic                        pol_high;

	logic              play_on;
	int unsigned       play_step;
	logic [31:0]       play_t0;
	logic [1:0]        cur_mode;
	logic              blink_q;
	logic [31:0]       toggle_t;
	logic              lit_q;

	lbmd_pkg::led_out_t led_expected_q[$];
	int unsigned       err_cnt;
	int unsigned       res_cnt;
	int unsigned       busy_cnt;

	function automatic lbmd_pkg::led_out_t predict_led(input lbmd_pkg::tick_t t);
		lbmd_pkg::led_out_t r;
		logic        busy;
		logic [31:0] dur;
		logic [15:0] half;
		busy = 1'b0;
		if (t.start_morse) begin
			play_on   = 1'b1;
			play_step = 0;
			play_t0   = t.now_ms;
		end
		if (play_on) begin
			if (play_step >= lbmd_pkg::PATTERN_STEPS_DEF) begin
				// pattern finished on the previous tick; mode logic takes over now
				play_on   = 1'b0;
				play_step = 0;
			end else begin
				busy  = 1'b1;
				lit_q = (play_step % 2) == 0;
				dur   = (play_step < 12) ? STEP_LEN[play_step] * unit_ms : unit_ms;
				if (t.now_ms - play_t0 >= dur) begin
					play_step++;
					play_t0 = t.now_ms;
				end
			end
		end
		if (!busy) begin
			if (t.mode != cur_mode) begin
				cur_mode = t.mode;
				toggle_t = t.now_ms;
				if (t.mode == lbmd_pkg::MODE_FAST || t.mode == lbmd_pkg::MODE_SLOW) begin
					blink_q = 1'b1;
					lit_q   = 1'b1;
				end
			end
			case (t.mode)
				lbmd_pkg::MODE_OFF: begin
					blink_q = 1'b0;
					lit_q   = 1'b0;
				end
				lbmd_pkg::MODE_SOLID: begin
					blink_q = 1'b1;
					lit_q   = 1'b1;
				end
				default: begin
					half = (t.mode == lbmd_pkg::MODE_FAST) ? fast_half : slow_half;
					if (t.now_ms - toggle_t > half) begin
						toggle_t = t.now_ms;
						blink_q  = !blink_q;
						lit_q    = blink_q;
					end
				end
			endcase
		end
		r.led_lit    = lit_q;
		r.pin_level  = lit_q ^ ~pol_high;
		r.morse_busy = busy;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lbmd_pkg::led_out_t want;
		if (!arst_n) begin
			fast_half = lbmd_pkg::FAST_HALF_RST;
			slow_half = lbmd_pkg::SLOW_HALF_RST;
			unit_ms   = lbmd_pkg::MORSE_UNIT_RST;
			pol_high  = lbmd_pkg::ACTIVE_HIGH_RST;
			play_on   = 1'b0;
			play_step = 0;
			play_t0   = '0;
			cur_mode  = lbmd_pkg::MODE_OFF;
			blink_q   = 1'b0;
			toggle_t  = '0;
			lit_q     = 1'b0;
			led_expected_q.delete();
			err_cnt   = 0;
			res_cnt   = 0;
			busy_cnt  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lbmd_pkg::REG_FAST_HALF:   fast_half = cfg_data[lbmd_pkg::HALF_W-1:0];
					lbmd_pkg::REG_SLOW_HALF:   slow_half = cfg_data[lbmd_pkg::HALF_W-1:0];
					lbmd_pkg::REG_MORSE_UNIT:  unit_ms   = cfg_data[lbmd_pkg::UNIT_W-1:0];
					lbmd_pkg::REG_ACTIVE_HIGH: pol_high  = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				led_expected_q.push_back(predict_led(in_data));
			if (out_valid && out_ready) begin
				res_cnt++;
				if (out_data.morse_busy === 1'b1)
					busy_cnt++;
				if (led_expected_q.size() == 0) begin
					err_cnt++;
					$display("%0t: LED beat with nothing expected: pin %b lit %b busy %b",
						$realtime, out_data.pin_level, out_data.led_lit, out_data.morse_busy);
				end else begin
					want = led_expected_q.pop_front();
					if (out_data !== want) begin
						err_cnt++;
						$display("%0t: LED mismatch: expected pin %b lit %b busy %b, got pin %b lit %b busy %b",
							$realtime, want.pin_level, want.led_lit, want.morse_busy,
							out_data.pin_level, out_data.led_lit, out_data.morse_busy);
					end
				end
			end
		end
		fails        <= err_cnt;
		pending      <= led_expected_q.size();
		results_seen <= res_cnt;
		busy_seen    <= busy_cnt;
	end

endmodule

// File: test/tb_led_blink_morse_driver.sv
// Testbench top: drives ticks and register writes into the LED driver and gives the verdict.
module tb_led_blink_morse_driver;
	timeunit 1ns;
	timeprecision 1ps;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_ready;
	lbmd_pkg::tick_t                  in_data;
	logic                             out_valid;
	logic                             out_ready;
	lbmd_pkg::led_out_t               out_data;
	logic                             cfg_we;
	logic [lbmd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lbmd_pkg::CFG_DATA_W-1:0]  cfg_data;

	int unsigned fails;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned busy_seen;

	logic        offering;
	logic        rx_hold;
	int unsigned quiet_left;
	int unsigned ticks_sent;
	int unsigned settings_run;
	logic [31:0] now_t;
	logic [1:0]  mode_t;

	led_blink_morse_driver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lbmd_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fails        (fails),
		.pending      (pending),
		.results_seen (results_seen),
		.busy_seen    (busy_seen)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver: random stalls, one long hold-off while ticks keep coming
	initial begin
		logic        hold_done;
		int unsigned r;
		int unsigned len;
		hold_done = 1'b0;
		out_ready = 1'b0;
		rx_hold   = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!hold_done && offering && results_seen >= 300) begin
				out_ready <= 1'b0;
				rx_hold   <= 1'b1;
				repeat (60) @(posedge clk);
				rx_hold   <= 1'b0;
				hold_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready <= 1'b1;
					len = $urandom_range(1, 12);
				end else if (r < 70) begin
					out_ready <= 1'b1;
					len = 80;
				end else if (r < 95) begin
					out_ready <= 1'b0;
					len = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					len = $urandom_range(8, 30);
				end
				repeat (len) @(posedge clk);
			end
		end
	end

	// offers one tick after a random gap and waits until it is accepted
	task automatic send_tick(input logic [31:0] t, input logic [1:0] m, input logic s);
		int unsigned r;
		int unsigned gap;
		gap = 0;
		if (rx_hold) begin
			gap = 0;
		end else if (quiet_left > 0) begin
			quiet_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 45)
				gap = 0;
			else if (r < 80)
				gap = $urandom_range(1, 2);
			else if (r < 93)
				gap = $urandom_range(3, 8);
			else if (r < 97)
				gap = $urandom_range(15, 40);
			else
				quiet_left = 40;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{now_ms: t, mode: m, start_morse: s};
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	// stop offering, let every result come back, then load a new timing set
	task automatic set_timing(input logic [15:0] fast, input logic [15:0] slow,
			input logic [15:0] unit, input logic [15:0] pol);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		cfg_we <= 1'b1; cfg_index <= lbmd_pkg::REG_FAST_HALF;   cfg_data <= fast; @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= lbmd_pkg::REG_SLOW_HALF;   cfg_data <= slow; @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= lbmd_pkg::REG_MORSE_UNIT;  cfg_data <= unit; @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= lbmd_pkg::REG_ACTIVE_HIGH; cfg_data <= pol;  @(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// mostly advancing time with sticky modes; a few jumps to random ticks
	task automatic run_ticks(input int unsigned n, input int unsigned step_max);
		logic start;
		if ($urandom_range(0, 1))
			now_t = 32'hFFFF_FFFF - $urandom_range(0, step_max * 20);
		else
			now_t = $urandom;
		offering = 1'b1;
		repeat (n) begin
			if ($urandom_range(0, 99) < 8) begin
				now_t  = $urandom;
				mode_t = 2'($urandom_range(0, 3));
				start  = 1'($urandom_range(0, 1));
			end else begin
				now_t = now_t + $urandom_range(0, step_max);
				if ($urandom_range(0, 9) == 0)
					mode_t = 2'($urandom_range(0, 3));
				start = ($urandom_range(0, 24) == 0);
			end
			send_tick(now_t, mode_t, start);
		end
		offering = 1'b0;
	endtask

	initial begin
		logic [31:0] t;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_we       = 1'b0;
		cfg_index    = lbmd_pkg::REG_FAST_HALF;
		cfg_data     = '0;
		offering     = 1'b0;
		quiet_left   = 0;
		ticks_sent   = 0;
		settings_run = 1;
		now_t        = '0;
		mode_t       = lbmd_pkg::MODE_OFF;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset timing: strict half-period compare, wrap, full pattern
		send_tick(32'd0, lbmd_pkg::MODE_OFF, 1'b0);
		send_tick(32'hFFFF_FFFF, lbmd_pkg::MODE_SOLID, 1'b0);
		send_tick(32'hFFFF_FFFF, lbmd_pkg::MODE_FAST, 1'b0);
		send_tick(32'd180, lbmd_pkg::MODE_FAST, 1'b0);
		send_tick(32'd360, lbmd_pkg::MODE_FAST, 1'b0);
		send_tick(32'd361, lbmd_pkg::MODE_FAST, 1'b0);
		t = 32'd500;
		send_tick(t, lbmd_pkg::MODE_SLOW, 1'b1);
		// one step per tick, then the end beat, then mode logic resumes
		repeat (14) begin
			t = t + 32'd210;
			send_tick(t, lbmd_pkg::MODE_SLOW, 1'b0);
		end
		send_tick(t + 32'd1, lbmd_pkg::MODE_SLOW, 1'b1);
		send_tick(t + 32'd2, lbmd_pkg::MODE_OFF, 1'b1);
		send_tick(t + 32'd5000, lbmd_pkg::MODE_SOLID, 1'b0);

		run_ticks(120, 120);
		set_timing(16'd3, 16'd7, 16'd2, 16'd0);
		run_ticks(130, 6);
		// zero unit and half-periods
		set_timing(16'd0, 16'd0, 16'd0, 16'd1);
		run_ticks(130, 2);
		set_timing(16'hFFFF, 16'hFFFF, 16'd4095, 16'd1);
		run_ticks(120, 20000);
		set_timing(16'd1, 16'd1, 16'd1, 16'd0);
		run_ticks(130, 3);
		set_timing(16'($urandom_range(1, 300)), 16'($urandom_range(1, 800)),
			16'($urandom_range(1, 150)), 16'($urandom_range(0, 1)));
		run_ticks(130, 200);

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);

		$display("%0d ticks over %0d timing sets, %0d LED beats checked",
			ticks_sent, settings_run, results_seen);
		$display("%0d beats came from pattern playback", busy_seen);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
